>>> hw/rtl/sip_pkg.sv
`default_nettype none
package sip_pkg;
	localparam int MaxRows = 4096;
	localparam int RowW = $clog2(MaxRows);
	localparam int MaxParts = 64;
	localparam int SegW = 7;
	localparam int IdW = 64;
	localparam int ColW = 32;
	localparam int QDepth = 2;

	typedef enum logic [2:0] {
		CFG_PARTS = 3'd0,
		CFG_TOTAL = 3'd1,
		CFG_DIV = 3'd2,
		CFG_PRUNE = 3'd3,
		CFG_FILL = 3'd4,
		CFG_DKEY = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [SegW-1:0] parts;
		logic [30:0] total;
		logic use_div;
		logic prune;
		logic fill;
		logic [30:0] dkey;
	} cfg_t;

	// Work for the back end: divide or pass through.
	typedef struct packed {
		logic need_div;
		logic [IdW-1:0] val;
		logic [SegW-1:0] seg;
		logic [RowW-1:0] row;
		logic [ColW-1:0] col;
		logic valid;
		logic empty;
		logic fill;
		logic err;
	} job_t;

	typedef struct packed {
		logic [SegW-1:0] seg;
		logic [IdW-1:0] loc;
		logic [RowW-1:0] row;
		logic [ColW-1:0] col;
		logic valid;
		logic empty;
		logic fill;
		logic err;
	} res_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PREP,
		BK_DIV,
		BK_SEG,
		BK_OUT
	} bk_state_t;
endpackage
`default_nettype wire

>>> hw/rtl/sip_front.sv
`default_nettype none
module sip_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire sip_pkg::cfg_t cfg,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic cmd,
	input wire logic [sip_pkg::RowW-1:0] row,
	input wire logic [sip_pkg::ColW-1:0] col,
	input wire logic [sip_pkg::IdW-1:0] id,
	output logic job_valid,
	input wire logic job_ready,
	output sip_pkg::job_t job
);
	// Row bitmap: one read and at most one write per item.
	logic seen_mem [sip_pkg::MaxRows];
	logic busy_q;
	logic rd_q;
	logic cmd_q;
	logic [sip_pkg::RowW-1:0] row_q;
	logic [sip_pkg::ColW-1:0] col_q;
	logic [sip_pkg::IdW-1:0] id_q;
	logic clr_busy_q;
	logic [sip_pkg::RowW-1:0] clr_cnt_q;
	logic [sip_pkg::SegW-1:0] p_eff;
	logic neg;

	always_comb begin
		p_eff = cfg.parts;
		if (cfg.parts == '0) p_eff = sip_pkg::SegW'(1);
		if (cfg.parts > sip_pkg::SegW'(sip_pkg::MaxParts))
			p_eff = sip_pkg::SegW'(sip_pkg::MaxParts);
	end

	assign in_ready = !busy_q && !clr_busy_q;
	assign neg = id_q[sip_pkg::IdW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == '1) clr_busy_q <= 1'b0;
			end
			if (in_valid && in_ready) busy_q <= 1'b1;
			else if (job_valid && job_ready) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) seen_mem[clr_cnt_q] <= 1'b0;
		if (in_valid && in_ready) begin
			cmd_q <= cmd;
			row_q <= row;
			col_q <= col;
			id_q <= id;
			rd_q <= seen_mem[row];
		end
		if (job_valid && job_ready) begin
			if (cmd_q) seen_mem[row_q] <= 1'b0;
			else if (!(neg && cfg.prune)) seen_mem[row_q] <= 1'b1;
		end
	end

	assign job_valid = busy_q;

	always_comb begin
		job = '0;
		job.row = row_q;
		if (!cmd_q) begin
			job.col = col_q;
			if (neg) begin
				job.val = id_q;
				job.seg = cfg.prune ? p_eff : '0;
			end else begin
				job.valid = 1'b1;
				job.need_div = 1'b1;
				job.val = id_q;
			end
		end else begin
			job.empty = !rd_q;
			if (!rd_q && cfg.fill) begin
				job.fill = 1'b1;
				job.valid = 1'b1;
				job.need_div = 1'b1;
				job.val = {33'd0, cfg.dkey};
			end
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/sip_queue.sv
`default_nettype none
module sip_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_valid,
	output logic wr_ready,
	input wire sip_pkg::job_t wr_data,
	output logic rd_valid,
	input wire logic rd_ready,
	output sip_pkg::job_t rd_data
);
	sip_pkg::job_t mem_q [sip_pkg::QDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != 2'(sip_pkg::QDepth);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

>>> hw/rtl/sip_back.sv
`default_nettype none
module sip_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire sip_pkg::cfg_t cfg,
	input wire logic job_valid,
	output logic job_ready,
	input wire sip_pkg::job_t job,
	output logic res_valid,
	input wire logic res_ready,
	output sip_pkg::res_t res
);
	sip_pkg::bk_state_t state_q, state_d;
	sip_pkg::job_t job_q;
	sip_pkg::res_t res_q;
	logic res_valid_q;
	logic [sip_pkg::IdW-1:0] num_q, quo_q;
	logic [sip_pkg::IdW-1:0] rem_q;
	logic [31:0] den_q;
	logic [6:0] step_q;
	logic [sip_pkg::SegW-1:0] p_eff;
	logic [31:0] per_q, extras_q, big_q;
	logic in_big_q;
	logic [1:0] phase_q;
	logic [sip_pkg::IdW:0] rem_sh;
	logic take;
	logic div_done;

	always_comb begin
		p_eff = cfg.parts;
		if (cfg.parts == '0) p_eff = sip_pkg::SegW'(1);
		if (cfg.parts > sip_pkg::SegW'(sip_pkg::MaxParts))
			p_eff = sip_pkg::SegW'(sip_pkg::MaxParts);
	end

	assign take = job_valid && job_ready;
	assign rem_sh = {rem_q, num_q[sip_pkg::IdW-1]};
	assign div_done = step_q == 7'd63;
	assign job_ready = state_q == sip_pkg::BK_IDLE;
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sip_pkg::BK_IDLE: if (job_valid)
				state_d = job.need_div ? sip_pkg::BK_PREP : sip_pkg::BK_OUT;
			sip_pkg::BK_PREP: state_d = sip_pkg::BK_DIV;
			sip_pkg::BK_DIV: if (div_done) state_d = sip_pkg::BK_SEG;
			sip_pkg::BK_SEG: state_d = (phase_q == 2'd0) ? sip_pkg::BK_PREP : sip_pkg::BK_OUT;
			sip_pkg::BK_OUT: if (!res_valid_q || res_ready) state_d = sip_pkg::BK_IDLE;
			default: state_d = sip_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sip_pkg::BK_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sip_pkg::BK_OUT && (!res_valid_q || res_ready))
				res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	// Mod rule: one division id / P. Div rule: total / P first (phase 0),
	// then the id against the chosen partition size (phase 1).
	always_ff @(posedge clk) begin
		unique case (state_q)
			sip_pkg::BK_IDLE: begin
				if (take) begin
					job_q <= job;
					phase_q <= (job.need_div && cfg.use_div) ? 2'd0 : 2'd1;
				end
			end
			sip_pkg::BK_PREP: begin
				step_q <= '0;
				rem_q <= '0;
				quo_q <= '0;
				if (phase_q == 2'd0) begin
					num_q <= {33'd0, cfg.total};
					den_q <= 32'(p_eff);
				end else if (!cfg.use_div) begin
					num_q <= job_q.val;
					den_q <= 32'(p_eff);
				end else if (job_q.val < {33'd0, big_q[30:0]} && in_big_q) begin
					num_q <= job_q.val;
					den_q <= per_q + 32'd1;
				end else begin
					num_q <= job_q.val - {32'd0, extras_q};
					den_q <= per_q;
				end
			end
			sip_pkg::BK_DIV: begin
				step_q <= step_q + 7'd1;
				num_q <= {num_q[sip_pkg::IdW-2:0], 1'b0};
				if (rem_sh >= {33'd0, den_q}) begin
					rem_q <= rem_sh[sip_pkg::IdW-1:0] - {32'd0, den_q};
					quo_q <= {quo_q[sip_pkg::IdW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[sip_pkg::IdW-1:0];
					quo_q <= {quo_q[sip_pkg::IdW-2:0], 1'b0};
				end
			end
			sip_pkg::BK_SEG: begin
				if (phase_q == 2'd0) begin
					per_q <= quo_q[31:0];
					extras_q <= rem_q[31:0];
					phase_q <= 2'd1;
					in_big_q <= 1'b1;
					big_q <= 32'(rem_q[6:0]) * (quo_q[31:0] + 32'd1);
					if (job_q.val >= {33'd0, cfg.total}) phase_q <= 2'd2;
				end else if (phase_q == 2'd1) begin
					// An id beyond the table keeps its raw value.
					job_q.seg <= quo_q[sip_pkg::SegW-1:0];
					job_q.val <= rem_q;
				end
			end
			sip_pkg::BK_OUT: begin
				if (!res_valid_q || res_ready) begin
					res_q.seg <= job_q.seg;
					res_q.loc <= job_q.val;
					res_q.row <= job_q.row;
					res_q.col <= job_q.col;
					res_q.valid <= job_q.valid;
					res_q.empty <= job_q.empty;
					res_q.fill <= job_q.fill;
					res_q.err <= 1'b0;
					if (!cfg.use_div) begin
						if (job_q.need_div) res_q.loc <= quo_q;
						if (job_q.need_div) res_q.seg <= rem_q[sip_pkg::SegW-1:0];
					end else if (job_q.need_div && phase_q == 2'd2) begin
						res_q.seg <= p_eff;
						res_q.err <= 1'b1;
					end
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> hw/rtl/sparse_id_partitioner.sv
// Channel  | Dir | Handshake          | Payload
// s_axis   | in  | tvalid/tready      | tdata {id,col,row}, tuser cmd
// m_axis   | out | tvalid/tready      | tdata {out_col,out_row,local_id,segment}, tuser flags
// cfg      | in  | cfg_valid/ready    | cfg_index, cfg_data
// After reset the row bitmap is cleared entry by entry; no item is taken then.
// An id entry under the mod rule makes one pass through the shared 64-step
// radix-2 divider; the div rule runs it twice.
// Pass-through items (negative ids, plain row checks) skip the divider.
// A two-entry queue parts the bitmap front end from the divider back end.
`default_nettype none
module sparse_id_partitioner (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [111:0] s_axis_tdata, // row[11:0], col[43:12], id[107:44], zeros
	input wire logic s_axis_tuser, // cmd
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [119:0] m_axis_tdata, // segment, local_id, out_row, out_col, zeros
	output logic [3:0] m_axis_tuser, // id_valid, row_empty, is_fill, range_error
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	sip_pkg::cfg_t cfg_q;
	sip_pkg::job_t fj, bj;
	sip_pkg::res_t res;
	logic fv, fr, bv, br;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
			cfg_q.parts <= sip_pkg::SegW'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				sip_pkg::CFG_PARTS: cfg_q.parts <= cfg_data[6:0];
				sip_pkg::CFG_TOTAL: cfg_q.total <= cfg_data[30:0];
				sip_pkg::CFG_DIV: cfg_q.use_div <= cfg_data[0];
				sip_pkg::CFG_PRUNE: cfg_q.prune <= cfg_data[0];
				sip_pkg::CFG_FILL: cfg_q.fill <= cfg_data[0];
				sip_pkg::CFG_DKEY: cfg_q.dkey <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	sip_front u_front (.clk, .arst_n, .cfg(cfg_q), .in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready), .cmd(s_axis_tuser), .row(s_axis_tdata[11:0]),
		.col(s_axis_tdata[43:12]), .id(s_axis_tdata[107:44]),
		.job_valid(fv), .job_ready(fr), .job(fj));
	sip_queue u_queue (.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
		.rd_valid(bv), .rd_ready(br), .rd_data(bj));
	sip_back u_back (.clk, .arst_n, .cfg(cfg_q), .job_valid(bv), .job_ready(br),
		.job(bj), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res));

	assign m_axis_tdata = {5'd0, res.col, res.row, res.loc, res.seg};
	assign m_axis_tuser = {res.err, res.fill, res.empty, res.valid};
endmodule
`default_nettype wire

>>> hw/rtl/sip_checker.sv
`default_nettype none
module sip_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [119:0] m_axis_tdata,
	input wire logic [3:0] m_axis_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1] && m_axis_tuser[0])
		else $error("fill without empty");
	a_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[114:83] == 32'd0)
		else $error("row check column");
endmodule
bind sparse_id_partitioner sip_checker u_chk (.clk, .arst_n, .m_axis_tvalid,
	.m_axis_tready, .m_axis_tdata, .m_axis_tuser);
`default_nettype wire
